/* design/cdf_pkg.sv */
// shared types and constants of the circular decimating fir core
// no dependencies; imported by every other design file except cdf_ram
package cdf_pkg;

	// request opcodes
	localparam logic [1:0] OP_WR_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WR_TAP    = 2'd1;
	localparam logic [1:0] OP_COMPUTE   = 2'd2;

	// configuration register indexes
	localparam int          CFG_IW      = 3;
	localparam int          CFG_DW      = 18;
	localparam logic [2:0]  REG_RATE    = 3'd0;
	localparam logic [2:0]  REG_LEFT    = 3'd1;
	localparam logic [2:0]  REG_RIGHT   = 3'd2;
	localparam logic [2:0]  REG_SAMPLES = 3'd3;
	localparam logic [2:0]  REG_OUTPUTS = 3'd4;
	localparam logic [2:0]  REG_SCALE   = 3'd5;

	localparam int POS_W   = 12;
	localparam int DATA_W  = 16;
	localparam int SCALE_W = 18;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int MAX_RATE = 16;

	// rate * position + right taps fits in 17 bits
	localparam int DVD_W  = 17;
	localparam int DIV_CW = $clog2(DVD_W);

	// q2.30 products, summed, times q2.16 scale have 46 fraction bits, result keeps 15
	localparam int RND_SH = 31;

	typedef struct packed {
		logic [4:0]         rate;
		logic [5:0]         left;
		logic [5:0]         right;
		logic [12:0]        samples;
		logic [12:0]        outputs;
		logic signed [17:0] scale;
	} cfg_t;

	typedef struct packed {
		logic wr_sample;
		logic wr_tap;
		logic load;
		logic div_step;
		logic idx_load;
		logic issue;
		logic sc_lo;
		logic sc_hi;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic bad_req;
		logic last_tap;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

/* design/cdf_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module cdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/cdf_cfg.sv */
// configuration register bank, decodes the write port into cfg_t
// depends on cdf_pkg
module cdf_cfg
	import cdf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wen,
	input  logic [CFG_IW-1:0] index,
	input  logic [CFG_DW-1:0] wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate    <= 5'd1;
			cfg_q.left    <= 6'd0;
			cfg_q.right   <= 6'd0;
			cfg_q.samples <= 13'd1;
			cfg_q.outputs <= 13'd1;
			cfg_q.scale   <= 18'sd65536;
		end else if (wen) begin
			unique case (index)
				REG_RATE:    cfg_q.rate    <= wdata[4:0];
				REG_LEFT:    cfg_q.left    <= wdata[5:0];
				REG_RIGHT:   cfg_q.right   <= wdata[5:0];
				REG_SAMPLES: cfg_q.samples <= wdata[12:0];
				REG_OUTPUTS: cfg_q.outputs <= wdata[12:0];
				REG_SCALE:   cfg_q.scale   <= $signed(wdata);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/cdf_ctrl.sv */
// controller state machine: sequences store writes, modulo, tap walk and scaling
// depends on cdf_pkg; drives cmd_t into cdf_dp and reads its sts_t
module cdf_ctrl
	import cdf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_IDX   = 3'd2;
	localparam logic [2:0] ST_MAC   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_SLO   = 3'd5;
	localparam logic [2:0] ST_SHI   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DVD_W - 1);

	logic [2:0]        state_q, state_d;
	logic [DIV_CW-1:0] div_cnt_q;
	logic              accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_WR_SAMPLE: cmd.wr_sample = 1'b1;
						OP_WR_TAP:    cmd.wr_tap = 1'b1;
						OP_COMPUTE: begin
							cmd.load = 1'b1;
							state_d  = sts.bad_req ? ST_FIN : ST_DIV;
						end
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_IDX;
				end
			end
			ST_IDX: begin
				cmd.idx_load = 1'b1;
				state_d      = ST_MAC;
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				if (sts.last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_SLO;
				end
			end
			ST_SLO: begin
				cmd.sc_lo = 1'b1;
				state_d   = ST_SHI;
			end
			ST_SHI: begin
				cmd.sc_hi = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				// wait until the output register can take the result
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == DIV_LAST) |=> (state_q == ST_IDX))
		else $error("modulo did not finish after its last step");
	a_scale_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLO) |-> !sts.pipe_busy)
		else $error("scaling started with products still in flight");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (state_q == ST_IDLE))
		else $error("controller not idle after delivering a result");
`endif

endmodule

/* design/cdf_dp.sv */
// datapath: sample and tap stores, modulo unit, shared mac, scaling and output register
// depends on cdf_pkg and cdf_ram; controlled by cdf_ctrl through cmd_t and sts_t
module cdf_dp
	import cdf_pkg::*;
#(
	parameter int MAX_SAMPLES   = 4096,
	parameter int MAX_HALF_TAPS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] data_value,
	input  logic                     m_tready,
	output logic                     out_valid,
	output logic [POS_W-1:0]         out_position,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     clipped,
	output logic                     bad_position
);

	localparam int AW        = $clog2(MAX_SAMPLES);
	localparam int NW        = $clog2(MAX_SAMPLES + 1);
	localparam int TAP_SLOTS = 2 * MAX_HALF_TAPS + 1;
	localparam int SW        = $clog2(TAP_SLOTS);
	localparam int RW        = $clog2(MAX_HALF_TAPS + 1);
	localparam int ACC_W     = PROD_W + SW;
	localparam int LO_W      = (ACC_W + 1) / 2;
	localparam int MUL_A     = LO_W + 1;
	localparam int MUL_W     = MUL_A + SCALE_W;
	localparam int TOT_W     = ACC_W + SCALE_W;

	localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(64'sd1 <<< (RND_SH - 1));
	localparam logic signed [TOT_W-1:0] SAT_HI   = TOT_W'(32'sd32767);
	localparam logic signed [TOT_W-1:0] SAT_LO   = TOT_W'(-32'sd32768);

	// clamped configuration
	logic [4:0]    rate_c;
	logic [RW-1:0] lt_c, rt_c;
	logic [NW-1:0] n_c;

	always_comb begin
		if (cfg.rate == 5'd0) begin
			rate_c = 5'd1;
		end else if (int'(cfg.rate) > MAX_RATE) begin
			rate_c = 5'(MAX_RATE);
		end else begin
			rate_c = cfg.rate;
		end
		lt_c = (int'(cfg.left) > MAX_HALF_TAPS) ? RW'(MAX_HALF_TAPS) : RW'(cfg.left);
		rt_c = (int'(cfg.right) > MAX_HALF_TAPS) ? RW'(MAX_HALF_TAPS) : RW'(cfg.right);
		if (cfg.samples == 13'd0) begin
			n_c = NW'(1);
		end else if (int'(cfg.samples) > MAX_SAMPLES) begin
			n_c = NW'(MAX_SAMPLES);
		end else begin
			n_c = NW'(cfg.samples);
		end
	end

	// request registers
	logic [POS_W-1:0] pos_q;
	logic             bad_q;
	logic [NW-1:0]    n_q;
	logic [DVD_W-1:0] dvd_q;
	logic [NW-1:0]    rem_q;
	logic [AW-1:0]    idx_q;
	logic [SW-1:0]    slot_q, end_q;

	logic [DVD_W-1:0] dvd_c;
	logic [NW:0]      rem_sh;
	logic [NW-1:0]    rem_nx;

	assign dvd_c  = ({12'd0, rate_c} * {5'd0, position}) + DVD_W'(rt_c);
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_nx = (rem_sh >= {1'b0, n_q}) ? NW'(rem_sh - {1'b0, n_q}) : NW'(rem_sh);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= position;
			bad_q  <= ({1'b0, position} >= cfg.outputs);
			n_q    <= n_c;
			dvd_q  <= dvd_c;
			rem_q  <= '0;
			slot_q <= SW'(MAX_HALF_TAPS - int'(rt_c));
			end_q  <= SW'(MAX_HALF_TAPS + int'(lt_c));
		end else if (cmd.div_step) begin
			// restoring remainder, one dividend bit a step
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end else if (cmd.idx_load) begin
			idx_q <= rem_q[AW-1:0];
		end else if (cmd.issue) begin
			// offset rises by one, so the sample index falls by one, wrapping at n
			idx_q  <= (idx_q == '0) ? AW'(n_q - NW'(1)) : idx_q - 1'b1;
			slot_q <= slot_q + 1'b1;
		end
	end

	// stores
	logic                     samp_we, tap_we;
	logic signed [DATA_W-1:0] samp_rd, tap_rd;

	assign samp_we = cmd.wr_sample && (int'(position) < MAX_SAMPLES);
	assign tap_we  = cmd.wr_tap && (int'(position) < TAP_SLOTS);

	cdf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_SAMPLES)
	) u_samples (
		.clk  (clk),
		.we   (samp_we),
		.waddr(AW'(position)),
		.wdata(data_value),
		.raddr(idx_q),
		.rdata(samp_rd)
	);

	cdf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TAP_SLOTS)
	) u_taps (
		.clk  (clk),
		.we   (tap_we),
		.waddr(SW'(position)),
		.wdata(data_value),
		.raddr(slot_q),
		.rdata(tap_rd)
	);

	// mac pipeline: read, multiply, accumulate
	logic                     v_s1, v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= PROD_W'(samp_rd) * PROD_W'(tap_rd);
		end
		if (cmd.idx_load) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// scaling in two partial products: low half unsigned, high half signed
	logic signed [MUL_A-1:0] mul_a;
	logic signed [MUL_W-1:0] smul_q, plo_q;
	logic signed [TOT_W-1:0] total, rnd, qv;
	logic                    sat_hi, sat_lo;

	assign mul_a = cmd.sc_hi ? MUL_A'($signed(acc_q[ACC_W-1:LO_W]))
	                         : $signed({1'b0, acc_q[LO_W-1:0]});

	always_ff @(posedge clk) begin
		if (cmd.sc_lo || cmd.sc_hi) begin
			smul_q <= MUL_W'(mul_a) * MUL_W'(cfg.scale);
		end
		if (cmd.sc_hi) begin
			plo_q <= smul_q;
		end
	end

	assign total  = (TOT_W'(smul_q) <<< LO_W) + TOT_W'(plo_q);
	assign rnd    = total + RND_HALF;
	assign qv     = rnd >>> RND_SH;
	assign sat_hi = (qv > SAT_HI);
	assign sat_lo = (qv < SAT_LO);

	// output register
	logic                     out_valid_q;
	logic [POS_W-1:0]         out_pos_q;
	logic signed [DATA_W-1:0] out_val_q;
	logic                     clip_q, bad_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_pos_q <= pos_q;
			bad_out_q <= bad_q;
			priority if (bad_q) begin
				out_val_q <= '0;
				clip_q    <= 1'b0;
			end else if (sat_hi) begin
				out_val_q <= DATA_W'(SAT_HI);
				clip_q    <= 1'b1;
			end else if (sat_lo) begin
				out_val_q <= DATA_W'(SAT_LO);
				clip_q    <= 1'b1;
			end else begin
				out_val_q <= DATA_W'(qv);
				clip_q    <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;
	assign out_value    = out_val_q;
	assign clipped      = clip_q;
	assign bad_position = bad_out_q;

	assign sts.bad_req   = ({1'b0, position} >= cfg.outputs);
	assign sts.last_tap  = (slot_q == end_q);
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !out_valid_q || m_tready;

`ifndef ASSERT_OFF
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (slot_q <= end_q))
		else $error("tap walk ran past the last tap");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (NW'(idx_q) < n_q))
		else $error("sample index not below the wrap length");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && bad_q) |=> (out_val_q == '0 && !clip_q && bad_out_q))
		else $error("bad position result not zero");
`endif

endmodule

/* design/circular_decimating_fir_core.sv */
// channel  | dir | contents
// s_*      | in  | requests: tuser opcode, tdata position and data_value
// m_*      | out | results: tdata out_position and out_value, tuser flags
// cfg_*    | in  | register writes, no read-back
//
// sample and tap writes need no sequencing; a compute request runs
// 17 modulo steps, one mac step per tap, pipeline drain and two scale steps;
// a position at or above output_count goes straight to a zero result flagged bad_position
// the single shared mac over the taps sets the rate; a pending result in the
// output register does not block write requests, only the next finishing compute
// reset clears control, valid flags and configuration only; both stores hold garbage until written
//
// top level, depends on cdf_pkg, cdf_cfg, cdf_ctrl, cdf_dp, cdf_ram
module circular_decimating_fir_core
	import cdf_pkg::*;
#(
	parameter int MAX_SAMPLES   = 4096,
	parameter int MAX_HALF_TAPS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // position[11:0], data_value[27:12], zero pad
	input  logic [1:0]        s_tuser,   // opcode[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // out_position[11:0], out_value[27:12], zero pad
	output logic [1:0]        m_tuser,   // clipped[0], bad_position[1]
	input  logic              cfg_wen,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t                     cfg;
	cmd_t                     cmd;
	sts_t                     sts;
	logic [POS_W-1:0]         out_position;
	logic signed [DATA_W-1:0] out_value;
	logic                     clipped, bad_position;

	cdf_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.wen   (cfg_wen),
		.index (cfg_index),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	cdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.opcode  (s_tuser),
		.sts     (sts),
		.cmd     (cmd)
	);

	cdf_dp #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.MAX_HALF_TAPS(MAX_HALF_TAPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.position    (s_tdata[11:0]),
		.data_value  ($signed(s_tdata[27:12])),
		.m_tready    (m_tready),
		.out_valid   (m_tvalid),
		.out_position(out_position),
		.out_value   (out_value),
		.clipped     (clipped),
		.bad_position(bad_position)
	);

	assign m_tdata = {4'd0, out_value, out_position};
	assign m_tuser = {bad_position, clipped};

endmodule
